[hw/rtl/cpg_pkg.sv]
// ----------------------------------------------------------------------------
// cpg_pkg: shared types and constants of the clothoid point generator
// Payload words, unit request bundles, state codes and the cordic angle table.
// ----------------------------------------------------------------------------
package cpg_pkg;

   localparam int unsigned POS_FRAC_BITS = 20;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_STEP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z    = 3'd3;

   localparam logic [20:0] STEP_RESET = 21'd1049;
   localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;
   localparam logic [63:0] CORDIC_GAIN = 64'd700114967507363238;

   typedef struct packed {
      logic               command;
      logic signed [31:0] heading;
      logic signed [47:0] curvature;
      logic signed [47:0] curvature_rate;
      logic signed [47:0] start_x;
      logic signed [47:0] start_y;
      logic signed [47:0] start_z;
      logic signed [31:0] grade;
      logic signed [47:0] grade_rate;
      logic        [35:0] segment_length;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] point_x;
      logic signed [47:0] point_y;
      logic signed [47:0] point_z;
      logic        [35:0] sample_index;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [6:0]  shift;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [35:0] dividend;
      logic [20:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
   } cordic_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_ROTATE,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      PH_S,
      PH_Q,
      PH_T1,
      PH_T2,
      PH_G1,
      PH_G2,
      PH_TURN,
      PH_RAD,
      PH_COS,
      PH_SIN
   } phase_type;

   // truncated series of atan(2^-n) in q60
   function automatic logic [63:0] atan_series(input int unsigned n);
      logic [63:0] sum;
      logic [63:0] term;
      int unsigned e;
      sum = '0;
      for (int unsigned k = 0; k < 32; k++) begin
         e = n * (2 * k + 1);
         if (e <= 60) begin
            term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
            if (k[0]) sum = sum - term;
            else sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_third();
      logic [63:0] sum;
      logic [63:0] p;
      logic [63:0] term;
      sum = '0;
      p = (64'd1 << 60) / 64'd3;
      for (int unsigned k = 0; k < 40; k++) begin
         if (p != 64'd0) begin
            term = p / 64'(2 * k + 1);
            if (k[0]) sum = sum - term;
            else sum = sum + term;
            p = p / 64'd9;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_q60(input int unsigned idx);
      logic [63:0] v;
      if (idx == 0) v = atan_series(1) + atan_third();
      else v = atan_series(idx);
      return v;
   endfunction

   localparam logic [63:0] RAD_SCALE = atan_q60(0) << 3;

endpackage

[hw/rtl/clothoid_point_generator.sv]
// ----------------------------------------------------------------------------
// clothoid_point_generator: samples points along a clothoid road segment
// A load word stores a segment; each step word yields the next 3-d point.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A load word runs the divider, one bit of
// the sample count a cycle, or skips it when the step is zero. A step word
// that yields a point takes ten products through the shared 64x16 digit
// multiplier and one pass down the chain of CORDIC_ITERATIONS rotation
// cells; a step past the segment end yields no point. The result sits in an
// output register, so a new word is taken while the last point waits.
module clothoid_point_generator #(
   parameter int unsigned CORDIC_ITERATIONS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cpg_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cpg_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_write,
   input  logic [cpg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cpg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [6:0] SH_Q  = 7'(cpg_pkg::POS_FRAC_BITS);
   localparam logic [6:0] SH_T1 = 7'(cpg_pkg::POS_FRAC_BITS + 8);
   localparam logic [6:0] SH_T2 = 7'(cpg_pkg::POS_FRAC_BITS + 17);

   cpg_pkg::state_type state_ff, state_in;
   cpg_pkg::phase_type phase_ff, phase_in;

   logic [20:0] step_ff;
   logic [47:0] offset_x_ff, offset_y_ff, offset_z_ff;

   logic [31:0] seg_heading_ff;
   logic [47:0] seg_curvature_ff, seg_curvature_rate_ff;
   logic [47:0] seg_start_x_ff, seg_start_y_ff, seg_start_z_ff;
   logic [31:0] seg_grade_ff;
   logic [47:0] seg_grade_rate_ff;
   logic [35:0] samples_total_ff;
   logic [35:0] next_index_ff;
   logic [47:0] accum_x_ff, accum_y_ff;

   logic [35:0] s_ff;
   logic [51:0] q_ff;
   logic [63:0] theta_ff;
   logic [1:0]  quad_ff;
   logic [47:0] z_ff;
   logic [63:0] cos_ff, sin_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   cpg_pkg::rsp_payload_type rsp_ff;

   cpg_pkg::mul_req_type mul_req;
   cpg_pkg::div_req_type div_req;
   logic                 mul_done;
   logic [63:0]          mul_res;
   logic                 div_done;
   logic [35:0]          div_quo;
   cpg_pkg::cordic_type  link [0:CORDIC_ITERATIONS];

   logic        accept;
   logic        load_take;
   logic        emit_take;
   logic        mul_capture;
   logic [63:0] ang_bias;
   logic [1:0]  quad;
   logic [35:0] s_sat;
   logic [35:0] index_inc;

   assign req_stall = (state_ff != cpg_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign load_take = accept && (req_payload.command == cpg_pkg::CMD_LOAD);
   assign mul_capture = (state_ff == cpg_pkg::ST_MUL_WAIT) && mul_done;
   assign ang_bias = mul_res + 64'h2000_0000_0000_0000;
   assign quad = ang_bias[63:62];
   assign s_sat = (|mul_res[63:36]) ? '1 : mul_res[35:0];
   assign index_inc = next_index_ff + 36'd1;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpg_pkg::ST_IDLE;
         phase_ff <= cpg_pkg::PH_S;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      emit_take = 1'b0;
      mul_req.start = 1'b0;
      mul_req.a = '0;
      mul_req.b = '0;
      mul_req.shift = '0;
      div_req.start = 1'b0;
      div_req.dividend = req_payload.segment_length;
      div_req.divisor = step_ff;

      unique case (phase_ff)
         cpg_pkg::PH_S: begin
            mul_req.a = {28'd0, next_index_ff};
            mul_req.b = {43'd0, step_ff};
            mul_req.shift = 7'd0;
         end
         cpg_pkg::PH_Q: begin
            mul_req.a = {28'd0, s_ff};
            mul_req.b = {28'd0, s_ff};
            mul_req.shift = SH_Q;
         end
         cpg_pkg::PH_T1: begin
            mul_req.a = {28'd0, s_ff};
            mul_req.b = {{16{seg_curvature_ff[47]}}, seg_curvature_ff};
            mul_req.shift = SH_T1;
         end
         cpg_pkg::PH_T2: begin
            mul_req.a = {12'd0, q_ff};
            mul_req.b = {{16{seg_curvature_rate_ff[47]}}, seg_curvature_rate_ff};
            mul_req.shift = SH_T2;
         end
         cpg_pkg::PH_G1: begin
            mul_req.a = {28'd0, s_ff};
            mul_req.b = {{32{seg_grade_ff[31]}}, seg_grade_ff};
            mul_req.shift = 7'd28;
         end
         cpg_pkg::PH_G2: begin
            mul_req.a = {12'd0, q_ff};
            mul_req.b = {{16{seg_grade_rate_ff[47]}}, seg_grade_rate_ff};
            mul_req.shift = 7'd41;
         end
         cpg_pkg::PH_TURN: begin
            mul_req.a = theta_ff;
            mul_req.b = cpg_pkg::TURN_PER_RAD;
            mul_req.shift = 7'd32;
         end
         cpg_pkg::PH_RAD: begin
            mul_req.a = theta_ff;
            mul_req.b = cpg_pkg::RAD_SCALE;
            mul_req.shift = 7'd64;
         end
         cpg_pkg::PH_COS: begin
            mul_req.a = cos_ff;
            mul_req.b = {43'd0, step_ff};
            mul_req.shift = 7'd60;
         end
         cpg_pkg::PH_SIN: begin
            mul_req.a = sin_ff;
            mul_req.b = {43'd0, step_ff};
            mul_req.shift = 7'd60;
         end
         default: begin
            mul_req.a = '0;
         end
      endcase

      unique case (state_ff)
         cpg_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_payload.command == cpg_pkg::CMD_LOAD) begin
                  if (step_ff != 21'd0) begin
                     div_req.start = 1'b1;
                     state_in = cpg_pkg::ST_DIVIDE;
                  end
               end else if (next_index_ff < samples_total_ff) begin
                  phase_in = cpg_pkg::PH_S;
                  state_in = cpg_pkg::ST_MUL_ISSUE;
               end
            end
         end
         cpg_pkg::ST_DIVIDE: begin
            if (div_done) state_in = cpg_pkg::ST_IDLE;
         end
         cpg_pkg::ST_MUL_ISSUE: begin
            mul_req.start = 1'b1;
            state_in = cpg_pkg::ST_MUL_WAIT;
         end
         cpg_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = cpg_pkg::ST_MUL_ISSUE;
               unique case (phase_ff)
                  cpg_pkg::PH_S:    phase_in = cpg_pkg::PH_Q;
                  cpg_pkg::PH_Q:    phase_in = cpg_pkg::PH_T1;
                  cpg_pkg::PH_T1:   phase_in = cpg_pkg::PH_T2;
                  cpg_pkg::PH_T2:   phase_in = cpg_pkg::PH_G1;
                  cpg_pkg::PH_G1:   phase_in = cpg_pkg::PH_G2;
                  cpg_pkg::PH_G2:   phase_in = cpg_pkg::PH_TURN;
                  cpg_pkg::PH_TURN: phase_in = cpg_pkg::PH_RAD;
                  cpg_pkg::PH_RAD:  state_in = cpg_pkg::ST_ROTATE;
                  cpg_pkg::PH_COS:  phase_in = cpg_pkg::PH_SIN;
                  cpg_pkg::PH_SIN:  state_in = cpg_pkg::ST_EMIT;
                  default:          state_in = cpg_pkg::ST_IDLE;
               endcase
            end
         end
         cpg_pkg::ST_ROTATE: begin
            if (link[CORDIC_ITERATIONS].valid) begin
               phase_in = cpg_pkg::PH_COS;
               state_in = cpg_pkg::ST_MUL_ISSUE;
            end
         end
         cpg_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_take = 1'b1;
               state_in = cpg_pkg::ST_IDLE;
            end
         end
         default: state_in = cpg_pkg::ST_IDLE;
      endcase

      rsp_valid_in = emit_take || (rsp_valid_ff && rsp_stall);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= cpg_pkg::STEP_RESET;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            cpg_pkg::CSR_SAMPLE_STEP: step_ff <= csr_wdata[20:0];
            cpg_pkg::CSR_OFFSET_X:    offset_x_ff <= csr_wdata;
            cpg_pkg::CSR_OFFSET_Y:    offset_y_ff <= csr_wdata;
            cpg_pkg::CSR_OFFSET_Z:    offset_z_ff <= csr_wdata;
            default:                  step_ff <= step_ff;
         endcase
      end
   end

   // segment state
   always_ff @(posedge clock) begin
      if (reset) begin
         samples_total_ff <= '0;
         next_index_ff <= '0;
         accum_x_ff <= '0;
         accum_y_ff <= '0;
      end else begin
         if (load_take) begin
            samples_total_ff <= '0;
            next_index_ff <= '0;
            accum_x_ff <= '0;
            accum_y_ff <= '0;
         end
         if (state_ff == cpg_pkg::ST_DIVIDE && div_done) samples_total_ff <= div_quo;
         if (mul_capture && phase_ff == cpg_pkg::PH_COS) accum_x_ff <= accum_x_ff + mul_res[47:0];
         if (mul_capture && phase_ff == cpg_pkg::PH_SIN) accum_y_ff <= accum_y_ff + mul_res[47:0];
         if (emit_take) next_index_ff <= index_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         seg_heading_ff <= req_payload.heading;
         seg_curvature_ff <= req_payload.curvature;
         seg_curvature_rate_ff <= req_payload.curvature_rate;
         seg_start_x_ff <= req_payload.start_x;
         seg_start_y_ff <= req_payload.start_y;
         seg_start_z_ff <= req_payload.start_z;
         seg_grade_ff <= req_payload.grade;
         seg_grade_rate_ff <= req_payload.grade_rate;
      end
   end

   // working registers of one sample
   always_ff @(posedge clock) begin
      if (mul_capture) begin
         case (phase_ff)
            cpg_pkg::PH_S:  s_ff <= s_sat;
            cpg_pkg::PH_Q:  q_ff <= mul_res[51:0];
            cpg_pkg::PH_T1: theta_ff <= {{28{seg_heading_ff[31]}}, seg_heading_ff, 4'b0000}
                                        + mul_res;
            cpg_pkg::PH_T2: theta_ff <= theta_ff + mul_res;
            cpg_pkg::PH_G1: z_ff <= seg_start_z_ff + mul_res[47:0];
            cpg_pkg::PH_G2: z_ff <= z_ff + mul_res[47:0] + offset_z_ff;
            cpg_pkg::PH_TURN: begin
               // split off the quadrant, keep the remainder in [-1/8, 1/8) turn
               quad_ff <= quad;
               theta_ff <= mul_res - {quad, 62'd0};
            end
            default: quad_ff <= quad_ff;
         endcase
      end
      if (state_ff == cpg_pkg::ST_ROTATE && link[CORDIC_ITERATIONS].valid) begin
         case (quad_ff)
            2'd0: begin
               cos_ff <= link[CORDIC_ITERATIONS].x;
               sin_ff <= link[CORDIC_ITERATIONS].y;
            end
            2'd1: begin
               cos_ff <= 64'd0 - link[CORDIC_ITERATIONS].y;
               sin_ff <= link[CORDIC_ITERATIONS].x;
            end
            2'd2: begin
               cos_ff <= 64'd0 - link[CORDIC_ITERATIONS].x;
               sin_ff <= 64'd0 - link[CORDIC_ITERATIONS].y;
            end
            default: begin
               cos_ff <= link[CORDIC_ITERATIONS].y;
               sin_ff <= 64'd0 - link[CORDIC_ITERATIONS].x;
            end
         endcase
      end
      if (emit_take) begin
         rsp_ff.point_x <= seg_start_x_ff + accum_x_ff + offset_x_ff;
         rsp_ff.point_y <= seg_start_y_ff + accum_y_ff + offset_y_ff;
         rsp_ff.point_z <= z_ff;
         rsp_ff.sample_index <= next_index_ff;
         rsp_ff.last <= (index_inc == samples_total_ff);
      end
   end

   // rotation chain
   assign link[0].valid = mul_capture && (phase_ff == cpg_pkg::PH_RAD);
   assign link[0].x = cpg_pkg::CORDIC_GAIN;
   assign link[0].y = 64'd0;
   assign link[0].z = mul_res;

   for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
      cpg_cordic_cell #(
         .STAGE(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (link[g]),
         .cell_out (link[g+1])
      );
   end

   cpg_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_res  (mul_res)
   );

   cpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/cpg_mul.sv]
// ----------------------------------------------------------------------------
// cpg_mul: shared signed multiplier
// 64x64 signed product over four 16-bit digits, then an arithmetic shift.
// ----------------------------------------------------------------------------
module cpg_mul (
   input  logic                clock,
   input  logic                reset,
   input  cpg_pkg::mul_req_type mul_req,
   output logic                mul_done,
   output logic [63:0]         mul_res
);

   logic signed [63:0]  a_ff;
   logic        [63:0]  b_ff;
   logic        [6:0]   shift_ff;
   logic signed [127:0] acc_ff;
   logic signed [127:0] acc_in;
   logic        [1:0]   cnt_ff;
   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic        [63:0]  res_ff;
   logic signed [16:0]  dig;
   logic signed [80:0]  prod;
   logic signed [127:0] part;
   logic signed [127:0] shifted;

   // top digit carries the sign of b
   assign dig = {(cnt_ff == 2'd3) ? b_ff[15] : 1'b0, b_ff[15:0]};
   assign prod = 81'(a_ff) * 81'(dig);
   assign part = 128'(prod);
   assign acc_in = acc_ff + (part <<< {cnt_ff, 4'b0000});
   assign shifted = acc_ff >>> shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         done_ff <= fin_ff;
         fin_ff <= busy_ff && (cnt_ff == 2'd3);
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         a_ff <= $signed(mul_req.a);
         b_ff <= mul_req.b;
         shift_ff <= mul_req.shift;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff <= {16'h0000, b_ff[63:16]};
      end
      if (fin_ff) res_ff <= shifted[63:0];
   end

   assign mul_done = done_ff;
   assign mul_res = res_ff;

endmodule

[hw/rtl/cpg_div.sv]
// ----------------------------------------------------------------------------
// cpg_div: sample count divider
// Restoring division of the segment length by the step, one bit a cycle.
// ----------------------------------------------------------------------------
module cpg_div (
   input  logic                clock,
   input  logic                reset,
   input  cpg_pkg::div_req_type div_req,
   output logic                div_done,
   output logic [35:0]         div_quo
);

   logic [35:0] dvd_ff;
   logic [20:0] dsr_ff;
   logic [20:0] rem_ff;
   logic [35:0] quo_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [21:0] rem_sh;
   logic        ge;
   logic [21:0] rem_sub;

   assign rem_sh = {rem_ff, dvd_ff[35]};
   assign ge = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd35);
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd35) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[20:0] : rem_sh[20:0];
         quo_ff <= {quo_ff[34:0], ge};
         dvd_ff <= {dvd_ff[34:0], 1'b0};
      end
   end

   assign div_done = done_ff;
   assign div_quo = quo_ff;

endmodule

[hw/rtl/cpg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// cpg_cordic_cell: one rotation step of the cordic chain
// Turns x/y by atan(2^-STAGE) toward z = 0 and hands the word on.
// ----------------------------------------------------------------------------
module cpg_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cpg_pkg::cordic_type cell_in,
   output cpg_pkg::cordic_type cell_out
);

   localparam logic [63:0] ANGLE = cpg_pkg::atan_q60(STAGE);

   cpg_pkg::cordic_type cell_ff;
   logic [63:0] xs;
   logic [63:0] ys;

   assign xs = $signed(cell_in.x) >>> STAGE;
   assign ys = $signed(cell_in.y) >>> STAGE;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!cell_in.z[63]) begin
         cell_ff.x <= cell_in.x - ys;
         cell_ff.y <= cell_in.y + xs;
         cell_ff.z <= cell_in.z - ANGLE;
      end else begin
         cell_ff.x <= cell_in.x + ys;
         cell_ff.y <= cell_in.y - xs;
         cell_ff.z <= cell_in.z + ANGLE;
      end
   end

   assign cell_out = cell_ff;

endmodule

[hw/rtl/cpg_checker.sv]
// ----------------------------------------------------------------------------
// cpg_checker: port-level checks of the clothoid point generator
// Watches the two word channels over time.
// ----------------------------------------------------------------------------
module cpg_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input cpg_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input cpg_pkg::rsp_payload_type rsp_payload
);

   // a stalled point holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled point changed");

   // no point appears in the cycle after a word is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("point appeared right after accept");

   // the block only goes busy because it took a word
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("stall rose without an accepted word");

   // a new point comes out of busy work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("point appeared while idle");

endmodule

bind clothoid_point_generator cpg_checker u_checker (.*);
